@@ hdl/iirl_pkg.sv @@
// Shared constants, operation codes and the per-cell command bundle for the
// indexed insert/remove list. No dependencies.
package iirl_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int DATA_W   = 32;
    // width used for every index / occupancy compare
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd5;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd6;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic              accept;   // a transaction is taken this cycle
        logic              insert;   // open a slot at pos, write value there
        logic              remove;   // close the slot at pos
        logic              find;     // compare against value
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  occ;      // occupancy before the operation
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

@@ hdl/indexed_insert_remove_list.sv @@
// Top level of the indexed insert/remove list: operation decode, the row of
// list cells and the result register. Depends on iirl_pkg and iirl_cell.
//
// Usage:
//   Input channel s_valid/s_ready carries one operation per transaction:
//   s_op, s_position and s_value. Result channel m_valid/m_ready returns one
//   transaction per operation: m_found, m_count and m_status, in order.
//   Every cell of the row updates in parallel in the cycle the operation is
//   taken, for inserts and removals at any index. A find registers one
//   match bit per cell; the bits are ORed as the match stage advances.
//   Each result passes the match stage and then the output register.
//   Throughput: one operation per cycle while the receiver keeps up.
//   When the receiver stalls, one result waits in the output register and a
//   second in the match stage; s_ready then drops until m_ready returns.
//   Reset (aresetn low, synchronous) empties the list and drops both valid
//   flags; stored words are not cleared, as only held entries are ever read.
module indexed_insert_remove_list (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [iirl_pkg::OP_W-1:0]    s_op,
    input  logic [iirl_pkg::POS_W-1:0]   s_position,
    input  logic signed [iirl_pkg::DATA_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic [iirl_pkg::COUNT_W-1:0] m_count,
    output logic                         m_status
);
    import iirl_pkg::*;

    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic               pipe_valid_reg;
    logic [CMP_W-1:0]   pipe_count_reg;
    logic               pipe_status_reg;
    logic               m_valid_reg;
    logic               m_found_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_status_reg;

    logic               accept, advance;
    logic [CMP_W-1:0]   occ_ext, pos_ext, k;
    logic               full, empty, ok, ins, rem, fnd;
    logic [CMP_W-1:0]   count_after;
    cell_cmd_t          cmd;

    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_match;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !pipe_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign occ_ext = CMP_W'(occ_reg);
    assign pos_ext = CMP_W'(s_position);
    assign full    = occ_ext == CMP_W'(CAPACITY);
    assign empty   = occ_ext == '0;

    always_comb begin
        ok  = 1'b1;
        ins = 1'b0;
        rem = 1'b0;
        fnd = 1'b0;
        k   = '0;
        unique case (s_op)
            OP_PUSH_FRONT: begin
                ok  = !full;
                ins = 1'b1;
            end
            OP_PUSH_BACK: begin
                ok  = !full;
                ins = 1'b1;
                k   = occ_ext;
            end
            OP_INSERT_AT: begin
                ok  = !full && (pos_ext <= occ_ext);
                ins = 1'b1;
                k   = pos_ext;
            end
            OP_POP_FRONT: begin
                ok  = !empty;
                rem = 1'b1;
            end
            OP_POP_BACK: begin
                ok  = !empty;
                rem = 1'b1;
                k   = occ_ext - CMP_W'(1);
            end
            OP_REMOVE_AT: begin
                ok  = pos_ext < occ_ext;
                rem = 1'b1;
                k   = pos_ext;
            end
            OP_FIND: begin
                fnd = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        cmd.accept = accept;
        cmd.insert = accept && ok && ins;
        cmd.remove = accept && ok && rem;
        cmd.find   = fnd;
        cmd.pos    = k;
        cmd.occ    = occ_ext;
        cmd.value  = s_value;
    end

    always_comb begin
        count_after = occ_ext;
        if (cmd.insert) begin
            count_after = occ_ext + CMP_W'(1);
        end else if (cmd.remove) begin
            count_after = occ_ext - CMP_W'(1);
        end
    end

    assign occ_next = CNT_W'(count_after);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = cmd.value;
        end else begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_right
            assign right_d = cell_data[i+1];
        end
        iirl_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (CMP_W'(i)),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            if (accept) begin
                pipe_valid_reg <= 1'b1;
            end else if (advance) begin
                pipe_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= pipe_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pipe_count_reg  <= count_after;
            pipe_status_reg <= ok ? STATUS_DONE : STATUS_REJECTED;
        end
        if (advance && pipe_valid_reg) begin
            m_found_reg  <= |cell_match;
            m_count_reg  <= pipe_count_reg[COUNT_W-1:0];
            m_status_reg <= pipe_status_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;
    assign m_count  = m_count_reg;
    assign m_status = m_status_reg;

endmodule

@@ hdl/iirl_cell.sv @@
// One slot of the list: holds a word, shifts towards either neighbour and
// compares against the search word. Depends on iirl_pkg.
module iirl_cell (
    input  logic                      aclk,
    input  logic [iirl_pkg::CMP_W-1:0] cell_idx,
    input  iirl_pkg::cell_cmd_t       cmd,
    input  logic [iirl_pkg::DATA_W-1:0] left_data,
    input  logic [iirl_pkg::DATA_W-1:0] right_data,
    output logic [iirl_pkg::DATA_W-1:0] data,
    output logic                      match
);
    import iirl_pkg::*;

    logic [DATA_W-1:0] data_reg, data_next;
    logic              match_reg, match_next;
    logic              above, at_pos;

    assign above  = cell_idx > cmd.pos;
    assign at_pos = cell_idx == cmd.pos;

    always_comb begin
        data_next = data_reg;
        if (cmd.insert) begin
            if (above) begin
                data_next = left_data;
            end else if (at_pos) begin
                data_next = cmd.value;
            end
        end else if (cmd.remove) begin
            if (above || at_pos) begin
                data_next = right_data;
            end
        end
    end

    assign match_next = cmd.find && (cell_idx < cmd.occ) && (data_reg == cmd.value);

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (cmd.accept) begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule
